### src/pctl_pkg.sv
package pctl_pkg;

  localparam int unsigned DEV_W      = 16;
  localparam int unsigned FILE_W     = 32;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned SLOT_OUT_W = 5;
  localparam int unsigned BYTE_OUT_W = 12;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic ACT_GET   = 1'b0;
  localparam logic ACT_PROBE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic out_free;
  } status_t;

endpackage

### src/page_cache_tag_lookup_fifo_top.sv
// Tag lookup and FIFO replacement for a fully associative page cache.
// Input channel s_axis: one transfer per request, tuser selects get or probe.
// Output channel m_axis: one transfer per request with hit, slot, fill flag
// and the byte offset within the page.
// A request is taken only while the engine is idle. Its tag is compared with
// the tag memory one slot per cycle, starting at slot 0, through a registered
// read port; the scan stops at the first valid match.
// The scan ends at a hit in the matching slot, or for a miss once the last slot
// has been compared; the result is then loaded into the output register and the
// engine returns to idle, where the next request is taken.
// A get that misses writes the tag into the slot under the replacement
// pointer and advances the pointer, wrapping at SLOTS.
// Reset clears all valid bits and the pointer at once; no clearing pass.
// The result sits in an output register: a new request is still accepted
// while it waits, but the next result is held back until m_axis_tready
// frees that register.
module page_cache_tag_lookup_fifo_top
  import pctl_pkg::*;
#(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // device_id [15:0], file_id [47:16], byte_offset [79:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit [0], slot [5:1], must_fill [6], byte_in_page [18:7], zero [23:19]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  logic                  out_hit;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_fill;
  logic [BYTE_OUT_W-1:0] out_byte;

  pctl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pctl_dp #(
    .SLOTS      (SLOTS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_action_i (s_axis_tuser),
    .in_device_i (s_axis_tdata[15:0]),
    .in_file_i   (s_axis_tdata[47:16]),
    .in_offset_i (s_axis_tdata[79:48]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_slot_o  (out_slot),
    .out_fill_o  (out_fill),
    .out_byte_o  (out_byte)
  );

  assign m_axis_tdata = {5'b0, out_byte, out_fill, out_slot, out_hit};

endmodule

### src/pctl_ctrl.sv
module pctl_ctrl
  import pctl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.match || status_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/pctl_dp.sv
module pctl_dp
  import pctl_pkg::*;
#(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  in_action_i,
  input  logic [DEV_W-1:0]      in_device_i,
  input  logic [FILE_W-1:0]     in_file_i,
  input  logic [OFF_W-1:0]      in_offset_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_hit_o,
  output logic [SLOT_OUT_W-1:0] out_slot_o,
  output logic                  out_fill_o,
  output logic [BYTE_OUT_W-1:0] out_byte_o
);

  localparam int unsigned SW     = $clog2(SLOTS);
  localparam int unsigned OFFS_W = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W = OFF_W - OFFS_W;
  localparam int unsigned TAG_W  = DEV_W + FILE_W + PAGE_W;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic [TAG_W-1:0]  tag_mem [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  logic [SW-1:0]     ptr_q;

  logic              action_q;
  logic [TAG_W-1:0]  tag_q;
  logic [OFFS_W-1:0] within_q;

  logic [SW-1:0]     scan_idx_q;
  logic              addr_done_q;
  logic [TAG_W-1:0]  rd_tag_q;
  logic [SW-1:0]     rd_idx_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic [SW-1:0]     hit_slot_q;

  logic              out_valid_q;
  logic              out_hit_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic              out_fill_q;
  logic [BYTE_OUT_W-1:0] out_byte_q;

  logic              issue;
  logic              match;
  logic              alloc;
  logic [SW-1:0]     res_slot;

  assign issue = cmd_i.scan && !addr_done_q;
  assign match = rd_vld_q && valid_q[rd_idx_q] && (rd_tag_q == tag_q);
  assign alloc = !hit_q && (action_q == ACT_GET);
  assign res_slot = alloc ? ptr_q : (hit_q ? hit_slot_q : '0);

  assign status_o.match    = match;
  assign status_o.last     = rd_vld_q && (rd_idx_q == LAST) && !match;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      action_q <= in_action_i;
      tag_q    <= {in_device_i, in_file_i, in_offset_i[OFF_W-1:OFFS_W]};
      within_q <= in_offset_i[OFFS_W-1:0];
    end
    if (issue) begin
      rd_tag_q <= tag_mem[scan_idx_q];
      rd_idx_q <= scan_idx_q;
    end
    if (cmd_i.finish && alloc) begin
      tag_mem[ptr_q] <= tag_q;
    end
    if (cmd_i.scan && match) begin
      hit_slot_q <= rd_idx_q;
    end
    if (cmd_i.finish) begin
      out_hit_q  <= hit_q;
      out_slot_q <= SLOT_OUT_W'(res_slot);
      out_fill_q <= alloc;
      out_byte_q <= BYTE_OUT_W'(within_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ptr_q       <= '0;
      scan_idx_q  <= '0;
      addr_done_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_idx_q  <= '0;
        addr_done_q <= 1'b0;
        rd_vld_q    <= 1'b0;
        hit_q       <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_idx_q == LAST) begin
            addr_done_q <= 1'b1;
          end
        end
        if (cmd_i.scan && match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish && alloc) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q          <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_slot_o  = out_slot_q;
  assign out_fill_o  = out_fill_q;
  assign out_byte_o  = out_byte_q;

  a_alloc_sets_valid : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && alloc) |=> valid_q[$past(ptr_q)]
  ) else $error("allocated slot not marked valid");

  a_hit_no_fill : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_fill_q)
  ) else $error("result reports both hit and fill");

  a_probe_keeps_ptr : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (action_q == ACT_PROBE)) |=> $stable(ptr_q)
  ) else $error("probe moved the replacement pointer");

  a_match_only_scanned : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    match |-> valid_q[rd_idx_q]
  ) else $error("match on an invalid slot");

endmodule
